FILE: rtl/pgc_pkg.sv
`default_nettype none
package pgc_pkg;

   localparam int FINE_NODES   = 4096;
   localparam int COARSE_NODES = 1024;

   localparam int FINE_AW   = (FINE_NODES > 1) ? $clog2(FINE_NODES) : 1;
   localparam int COARSE_AW = (COARSE_NODES > 1) ? $clog2(COARSE_NODES) : 1;

   localparam int CMD_W    = 2;
   localparam int NODE_W   = 12;
   localparam int AGG_W    = 10;
   localparam int WEIGHT_W = 16;
   localparam int VALUE_W  = 32;
   localparam int ACC_W    = 48;
   localparam int FCNT_W   = 13;
   localparam int CCNT_W   = 11;
   localparam int CSR_W    = 13;

   localparam int MUL_AW  = 33;
   localparam int MUL_BW  = 17;
   localparam int PROD_W  = MUL_AW + MUL_BW;
   localparam int P1_W    = WEIGHT_W + VALUE_W;
   localparam int WIDE_W  = 64;
   localparam int FRAC_SH = 28;

   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DIAG = 2'd1;
   localparam logic [CMD_W-1:0] CMD_OFF  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd3;

   localparam logic CSR_FINE_COUNT   = 1'b0;
   localparam logic CSR_COARSE_COUNT = 1'b1;

   localparam logic KIND_ENTRY = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK_A,
      ST_LOOK_B,
      ST_CHECK,
      ST_MUL_P1,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_ROUND,
      ST_ADD,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      MAC_HOLD,
      MAC_P1,
      MAC_HI,
      MAC_LO,
      MAC_RND
   } mac_op_type;

endpackage
`default_nettype wire

FILE: rtl/pgc_mac.sv
`default_nettype none
module pgc_mac
   import pgc_pkg::*;
(
   input  wire logic                       clock,
   input  wire mac_op_type                 op,
   input  wire logic signed [VALUE_W-1:0]  value,
   input  wire logic signed [WEIGHT_W-1:0] weight_a,
   input  wire logic signed [WEIGHT_W-1:0] weight_b,
   input  wire logic signed [ACC_W-1:0]    diag,
   output logic signed [ACC_W-1:0]         product,
   output logic signed [ACC_W-1:0]         sum
);

   logic signed [MUL_AW-1:0] mul_a;
   logic signed [MUL_BW-1:0] mul_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [P1_W-1:0]   p1_ff;
   logic signed [WIDE_W-1:0] acc_ff;
   logic signed [WIDE_W-1:0] rnd_sum;
   logic signed [WIDE_W-1:0] rnd_shift;
   logic signed [ACC_W-1:0]  rnd_ff;
   logic signed [ACC_W:0]    sum_wide;

   always_comb begin
      unique case (op)
         MAC_P1: begin
            mul_a = MUL_AW'(value);
            mul_b = MUL_BW'(weight_a);
         end
         MAC_HI: begin
            mul_a = MUL_AW'($signed(p1_ff[P1_W-1:16]));
            mul_b = MUL_BW'(weight_b);
         end
         MAC_LO: begin
            mul_a = $signed({{(MUL_AW-16){1'b0}}, p1_ff[15:0]});
            mul_b = MUL_BW'(weight_b);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign rnd_sum   = acc_ff + $signed(WIDE_W'(64'd1 << (FRAC_SH - 1)));
   assign rnd_shift = rnd_sum >>> FRAC_SH;

   always_ff @(posedge clock) begin
      unique case (op)
         MAC_P1:  p1_ff  <= prod[P1_W-1:0];
         MAC_HI:  acc_ff <= $signed({prod[ACC_W-1:0], 16'b0});
         MAC_LO:  acc_ff <= acc_ff + WIDE_W'(prod);
         MAC_RND: rnd_ff <= rnd_shift[ACC_W-1:0];
         default: ;
      endcase
   end

   assign product  = rnd_ff;
   assign sum_wide = (ACC_W+1)'(diag) + (ACC_W+1)'(rnd_ff);

   always_comb begin
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         sum = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sum = sum_wide[ACC_W-1:0];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/pwc_galerkin_coarsen.sv
// Galerkin coarsening under a piecewise-constant aggregation.
// Input channel req_*: one command word per handshake (valid high, stall low).
//   Load mapping writes the aggregate and weight of a fine node, diagonal
//   and off-diagonal words scale by the node weights, read returns a coarse
//   diagonal entry. Output channel rsp_* carries at most one word per input.
// Config port csr_*: index 0 fine_count, index 1 coarse_count; the user must see
//   that they are written only while the block is idle; the block does not enforce it.
// Throughput: one input at a time; req_stall is high until the word is done.
//   Load writes on acceptance. Diagonal steps LOOK_A, CHECK, MUL_P1, MUL_HI,
//   MUL_LO, ROUND, ADD; off-diagonal adds LOOK_B after LOOK_A and EMIT after
//   ADD when it emits an entry; read steps READ, EMIT. Out of range at the
//   input goes to EMIT; a mapped aggregate out of range goes from CHECK to
//   EMIT. The single shared 33x17 multiplier, used three times per product,
//   and the registered table and diagonal store reads set these steps.
// Reset: synchronous; afterwards the diagonal store is swept to zero, one
//   entry per cycle, all 1024 entries, with req_stall high. Config writes are taken.
// A stalled output word holds; the block keeps taking inputs until it has
//   another word to hand over, then waits for the output register to free.
`default_nettype none
module pwc_galerkin_coarsen
   import pgc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [CMD_W-1:0]           req_cmd,
   input  wire logic [NODE_W-1:0]          req_node_a,
   input  wire logic [NODE_W-1:0]          req_node_b,
   input  wire logic [AGG_W-1:0]           req_aggregate,
   input  wire logic signed [WEIGHT_W-1:0] req_weight,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_kind,
   output logic [AGG_W-1:0]                rsp_coarse_row,
   output logic [AGG_W-1:0]                rsp_coarse_col,
   output logic signed [ACC_W-1:0]         rsp_result_value,
   output logic                            rsp_status,
   input  wire logic                       csr_we,
   input  wire logic                       csr_index,
   input  wire logic [CSR_W-1:0]           csr_wdata
);

   localparam logic [FCNT_W-1:0] FINE_LIM   = FCNT_W'(FINE_NODES);
   localparam logic [CCNT_W-1:0] COARSE_LIM = CCNT_W'(COARSE_NODES);
   localparam int TAB_W = AGG_W + WEIGHT_W;

   state_type state_ff, state_in;
   mac_op_type mac_op;

   logic [FCNT_W-1:0] fine_count_ff;
   logic [CCNT_W-1:0] coarse_count_ff;
   logic [FCNT_W-1:0] fine_bound;
   logic [CCNT_W-1:0] coarse_bound;
   logic [COARSE_AW-1:0] clr_ff;

   logic accept;
   logic a_ok, b_ok, agg_ok, rd_ok, ca_ok, cb_ok;

   logic [CMD_W-1:0]          cmd_ff;
   logic [NODE_W-1:0]         a_ff;
   logic [NODE_W-1:0]         b_ff;
   logic signed [VALUE_W-1:0] v_ff;
   logic [AGG_W-1:0]          ca_ff;
   logic [AGG_W-1:0]          cb_ff;
   logic signed [WEIGHT_W-1:0] wa_ff;
   logic signed [WEIGHT_W-1:0] wb_ff;

   logic [TAB_W-1:0]   tab_mem [FINE_NODES];
   logic [TAB_W-1:0]   tab_q_ff;
   logic [FINE_AW-1:0] tab_raddr;
   logic               tab_we;

   logic signed [ACC_W-1:0] diag_mem [COARSE_NODES];
   logic signed [ACC_W-1:0] diag_q_ff;
   logic [COARSE_AW-1:0]    diag_raddr;
   logic [COARSE_AW-1:0]    diag_waddr;
   logic signed [ACC_W-1:0] diag_wdata;
   logic                    diag_we;

   logic signed [ACC_W-1:0] mac_product;
   logic signed [ACC_W-1:0] mac_sum;

   logic                    res_kind_ff;
   logic [AGG_W-1:0]        res_row_ff;
   logic [AGG_W-1:0]        res_col_ff;
   logic signed [ACC_W-1:0] res_val_ff;
   logic                    res_status_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_kind_ff;
   logic [AGG_W-1:0]        rsp_row_ff;
   logic [AGG_W-1:0]        rsp_col_ff;
   logic signed [ACC_W-1:0] rsp_val_ff;
   logic                    rsp_status_ff;
   logic                    out_free;
   logic                    out_load;

   assign fine_bound   = (fine_count_ff < FINE_LIM) ? fine_count_ff : FINE_LIM;
   assign coarse_bound = (coarse_count_ff < COARSE_LIM) ? coarse_count_ff : COARSE_LIM;

   assign a_ok   = {1'b0, req_node_a} < fine_bound;
   assign b_ok   = {1'b0, req_node_b} < fine_bound;
   assign agg_ok = {1'b0, req_aggregate} < coarse_bound;
   assign rd_ok  = {1'b0, req_node_a} < {2'b0, coarse_bound};
   assign ca_ok  = {1'b0, ca_ff} < coarse_bound;
   assign cb_ok  = {1'b0, cb_ff} < coarse_bound;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in   = state_ff;
      req_stall  = (state_ff != ST_IDLE);
      mac_op     = MAC_HOLD;
      tab_we     = 1'b0;
      tab_raddr  = FINE_AW'(req_node_a);
      diag_raddr = COARSE_AW'(req_node_a);
      diag_we    = 1'b0;
      diag_waddr = COARSE_AW'(ca_ff);
      diag_wdata = mac_sum;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            diag_we    = 1'b1;
            diag_waddr = clr_ff;
            diag_wdata = '0;
            if (clr_ff == COARSE_AW'(COARSE_NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_LOAD: begin
                     if (a_ok && agg_ok) begin
                        tab_we = 1'b1;
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end
                  CMD_DIAG: state_in = a_ok ? ST_LOOK_A : ST_EMIT;
                  CMD_OFF:  state_in = (a_ok && b_ok) ? ST_LOOK_A : ST_EMIT;
                  default:  state_in = rd_ok ? ST_READ : ST_EMIT;
               endcase
            end
         end
         ST_LOOK_A: begin
            tab_raddr = FINE_AW'(b_ff);
            state_in  = (cmd_ff == CMD_OFF) ? ST_LOOK_B : ST_CHECK;
         end
         ST_LOOK_B: state_in = ST_CHECK;
         ST_CHECK:  state_in = (ca_ok && cb_ok) ? ST_MUL_P1 : ST_EMIT;
         ST_MUL_P1: begin
            mac_op   = MAC_P1;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            mac_op   = MAC_HI;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            mac_op   = MAC_LO;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            mac_op     = MAC_RND;
            diag_raddr = COARSE_AW'(ca_ff);
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            if (ca_ff == cb_ff) begin
               diag_we  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_READ: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         fine_count_ff   <= FCNT_W'(4096);
         coarse_count_ff <= CCNT_W'(1024);
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_FINE_COUNT:   fine_count_ff   <= csr_wdata[FCNT_W-1:0];
               CSR_COARSE_COUNT: coarse_count_ff <= csr_wdata[CCNT_W-1:0];
               default: ;
            endcase
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         a_ff   <= req_node_a;
         b_ff   <= req_node_b;
         v_ff   <= req_value;
         res_kind_ff   <= (req_cmd == CMD_READ) ? KIND_READ : KIND_ENTRY;
         res_row_ff    <= '0;
         res_col_ff    <= '0;
         res_val_ff    <= '0;
         res_status_ff <= STATUS_RANGE;
      end
      if (state_ff == ST_LOOK_A) begin
         ca_ff <= tab_q_ff[TAB_W-1:WEIGHT_W];
         cb_ff <= tab_q_ff[TAB_W-1:WEIGHT_W];
         wa_ff <= $signed(tab_q_ff[WEIGHT_W-1:0]);
         wb_ff <= $signed(tab_q_ff[WEIGHT_W-1:0]);
      end
      if (state_ff == ST_LOOK_B) begin
         cb_ff <= tab_q_ff[TAB_W-1:WEIGHT_W];
         wb_ff <= $signed(tab_q_ff[WEIGHT_W-1:0]);
      end
      if (state_ff == ST_READ) begin
         res_kind_ff   <= KIND_READ;
         res_row_ff    <= a_ff[AGG_W-1:0];
         res_col_ff    <= '0;
         res_val_ff    <= diag_q_ff;
         res_status_ff <= STATUS_OK;
      end
      if (state_ff == ST_ADD) begin
         res_kind_ff   <= KIND_ENTRY;
         res_row_ff    <= (ca_ff < cb_ff) ? ca_ff : cb_ff;
         res_col_ff    <= (ca_ff < cb_ff) ? cb_ff : ca_ff;
         res_val_ff    <= mac_product;
         res_status_ff <= STATUS_OK;
      end
      if (out_load) begin
         rsp_kind_ff   <= res_kind_ff;
         rsp_row_ff    <= res_row_ff;
         rsp_col_ff    <= res_col_ff;
         rsp_val_ff    <= res_val_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[FINE_AW'(req_node_a)] <= {req_aggregate, req_weight};
      end
      tab_q_ff <= tab_mem[tab_raddr];
   end

   always_ff @(posedge clock) begin
      if (diag_we) begin
         diag_mem[diag_waddr] <= diag_wdata;
      end
      diag_q_ff <= diag_mem[diag_raddr];
   end

   pgc_mac u_mac (
      .clock    (clock),
      .op       (mac_op),
      .value    (v_ff),
      .weight_a (wa_ff),
      .weight_b (wb_ff),
      .diag     (diag_q_ff),
      .product  (mac_product),
      .sum      (mac_sum)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_coarse_row   = rsp_row_ff;
   assign rsp_coarse_col   = rsp_col_ff;
   assign rsp_result_value = rsp_val_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
`default_nettype wire
